[rtl/spc_pkg.sv]
// shared types and constants of the switch panel controller
package spc_pkg;

  // switch slots, in debounce order
  localparam int SW_LIGHTS = 0;
  localparam int SW_VALET  = 1;
  localparam int SW_DOORS  = 2;
  localparam int SW_ACC    = 3;
  localparam int NUM_SW    = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_HOLD_COUNT    = 2'd0;
  localparam logic [1:0] CFG_RELEASE_LEVEL = 2'd1;
  localparam logic [1:0] CFG_BLINK_PACE    = 2'd2;
  localparam logic [1:0] CFG_COMMIT_DELAY  = 2'd3;

  // configuration reset values
  localparam logic [7:0]  HOLD_COUNT_RST    = 8'hA0;
  localparam logic [7:0]  RELEASE_LEVEL_RST = 8'd10;
  localparam logic [11:0] BLINK_PACE_RST    = 12'h4B0;
  localparam logic [7:0]  COMMIT_DELAY_RST  = 8'd10;

  // blink counter: top bit slow, low bits steps left
  localparam logic [7:0] SLOW_BIT  = 8'h80;
  localparam logic [6:0] STEP_MASK = 7'h7F;

  localparam logic [7:0] BLINK_LIGHTS_ON  = 8'd8;
  localparam logic [7:0] BLINK_LIGHTS_OFF = SLOW_BIT | 8'd4;
  localparam logic [7:0] BLINK_ACC        = 8'd2;
  localparam logic [7:0] BLINK_VALET      = SLOW_BIT | 8'd20;
  localparam logic [7:0] BLINK_DOORS_ON   = 8'd16;
  localparam logic [7:0] BLINK_DOORS_OFF  = SLOW_BIT | 8'd6;

  // lamp position of each switch slot
  localparam logic [1:0] LAMP_POS [NUM_SW] = '{2'd0, 2'd3, 2'd2, 2'd1};

  // sound codes
  localparam logic [1:0] LSND_NONE   = 2'd0;
  localparam logic [1:0] LSND_ON     = 2'd1;
  localparam logic [1:0] LSND_OFF    = 2'd2;
  localparam logic [2:0] ASND_NONE   = 3'd0;
  localparam logic [2:0] ASND_LOW    = 3'd4;
  localparam logic [2:0] ASND_COMMIT = 3'd5;
  localparam logic [1:0] DSND_NONE   = 2'd0;
  localparam logic [1:0] DSND_PRESS  = 2'd1;
  localparam logic [1:0] DSND_REL    = 2'd2;

  // debounce status handed to the control logic
  typedef struct packed {
    logic [NUM_SW-1:0] hold;     // hold flags after this tick's debounce
    logic [NUM_SW-1:0] old_clr;  // old hold flags cleared by release
  } deb_stat_t;

  // blink counter loads from switch events
  typedef struct packed {
    logic [NUM_SW-1:0]       load;
    logic [NUM_SW-1:0][7:0]  value;
  } blink_load_t;

  // control part of one result
  typedef struct packed {
    logic       lights_relay;
    logic [2:0] acc_relays;
    logic [2:0] indicator_leds;
    logic [1:0] lights_sound;
    logic [2:0] acc_sound;
    logic       valet_sound;
    logic [1:0] doors_sound;
  } ctrl_res_t;

endpackage

[rtl/spc_if.sv]
// valid/ready channels carrying switch beats and result beats
interface spc_in_if;
  logic valid;
  logic ready;
  logic lights_switch;
  logic valet_switch;
  logic doors_switch;
  logic acc_switch;

  modport source (output valid, lights_switch, valet_switch, doors_switch, acc_switch,
                  input ready);
  modport sink (input valid, lights_switch, valet_switch, doors_switch, acc_switch,
                output ready);
endinterface

interface spc_out_if;
  logic       valid;
  logic       ready;
  logic       lights_relay;
  logic [2:0] acc_relays;
  logic [2:0] indicator_leds;
  logic [3:0] switch_lamps;
  logic [1:0] lights_sound;
  logic [2:0] acc_sound;
  logic       valet_sound;
  logic [1:0] doors_sound;

  modport source (output valid, lights_relay, acc_relays, indicator_leds, switch_lamps,
                  lights_sound, acc_sound, valet_sound, doors_sound,
                  input ready);
  modport sink (input valid, lights_relay, acc_relays, indicator_leds, switch_lamps,
                lights_sound, acc_sound, valet_sound, doors_sound,
                output ready);
endinterface

[rtl/spc_debounce.sv]
// integrating debounce counters and hold flags for the four switches
module spc_debounce (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [spc_pkg::NUM_SW-1:0]   pressed,
  input  logic                         lights_clear,
  input  logic [7:0]                   hold_count,
  input  logic [7:0]                   release_level,
  output spc_pkg::deb_stat_t           stat
);

  logic [7:0] cnt      [spc_pkg::NUM_SW];
  logic [7:0] cnt_next [spc_pkg::NUM_SW];
  logic [spc_pkg::NUM_SW-1:0] hold;

  // count up while pressed, down while released
  always_comb begin
    stat.hold    = hold;
    stat.old_clr = '0;
    for (int i = 0; i < spc_pkg::NUM_SW; i++) begin
      cnt_next[i] = cnt[i];
      if (pressed[i]) begin
        if (cnt[i] < hold_count) begin
          cnt_next[i] = cnt[i] + 8'd1;
        end else begin
          stat.hold[i] = 1'b1;
        end
      end else if (cnt[i] != 8'd0) begin
        if (cnt[i] < release_level) begin
          stat.hold[i] = 1'b0;
          // doors keeps its old flag until its release event
          stat.old_clr[i] = (i != spc_pkg::SW_DOORS);
        end
        cnt_next[i] = cnt[i] - 8'd1;
      end
    end
  end

  // a lights event restarts its counter
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= '0;
      for (int i = 0; i < spc_pkg::NUM_SW; i++) begin
        cnt[i] <= '0;
      end
    end else if (en) begin
      hold <= stat.hold;
      for (int i = 0; i < spc_pkg::NUM_SW; i++) begin
        cnt[i] <= (i == spc_pkg::SW_LIGHTS && lights_clear) ? 8'd0 : cnt_next[i];
      end
    end
  end

endmodule

[rtl/spc_blink.sv]
// blink pacer and per-lamp blink counters
module spc_blink (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [11:0]                  blink_pace,
  input  spc_pkg::blink_load_t         loads,
  output logic                         step,
  output logic [3:0]                   lamps_next
);

  logic [11:0] pace_cnt;
  logic [11:0] pace_cnt_next;
  logic [12:0] pace_inc;
  logic        parity;
  logic        parity_next;
  logic [7:0]  cnt      [spc_pkg::NUM_SW];
  logic [7:0]  cnt_next [spc_pkg::NUM_SW];
  logic [7:0]  cur      [spc_pkg::NUM_SW];
  logic [3:0]  lamps;

  // pacer compares the incremented count before wrapping
  always_comb begin
    pace_inc      = {1'b0, pace_cnt} + 13'd1;
    step          = pace_inc > {1'b0, blink_pace};
    pace_cnt_next = step ? 12'd0 : pace_inc[11:0];
    parity_next   = parity ^ step;
  end

  // event loads land first, then one blink step
  always_comb begin
    lamps_next = lamps;
    for (int i = 0; i < spc_pkg::NUM_SW; i++) begin
      cur[i]      = loads.load[i] ? loads.value[i] : cnt[i];
      cnt_next[i] = cur[i];
      if (step && (cur[i][6:0] & spc_pkg::STEP_MASK) != 7'd0 &&
          !((cur[i] & spc_pkg::SLOW_BIT) != 8'd0 && parity_next)) begin
        lamps_next[spc_pkg::LAMP_POS[i]] = ~cur[i][0];
        cnt_next[i] = cur[i] - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pace_cnt <= '0;
      parity   <= 1'b0;
      lamps    <= '0;
      for (int i = 0; i < spc_pkg::NUM_SW; i++) begin
        cnt[i] <= '0;
      end
    end else if (en) begin
      pace_cnt <= pace_cnt_next;
      parity   <= parity_next;
      lamps    <= lamps_next;
      for (int i = 0; i < spc_pkg::NUM_SW; i++) begin
        cnt[i] <= cnt_next[i];
      end
    end
  end

endmodule

[rtl/spc_ctrl.sv]
// switch events: lights toggle, accessory choice and commit, valet and doors
module spc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  spc_pkg::deb_stat_t   stat,
  input  logic                 step,
  input  logic [7:0]           commit_delay,
  output logic                 lights_clear,
  output spc_pkg::blink_load_t loads,
  output spc_pkg::ctrl_res_t   res
);

  typedef enum logic [1:0] {
    PH_WAIT      = 2'd0,
    PH_COMMITTED = 2'd1,
    PH_RESET     = 2'd2
  } phase_t;

  localparam int L = spc_pkg::SW_LIGHTS;
  localparam int V = spc_pkg::SW_VALET;
  localparam int D = spc_pkg::SW_DOORS;
  localparam int A = spc_pkg::SW_ACC;

  logic [3:0] old_hold;
  logic [3:0] old_hold_next;
  logic       lights_on;
  logic       lights_on_next;
  logic [1:0] choice;
  logic [1:0] choice_next;
  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] timer;
  logic [7:0] timer_next;
  logic [2:0] relays;
  logic [2:0] relays_next;
  logic [2:0] leds;
  logic [2:0] leds_next;
  logic [2:0] sel;

  always_comb begin
    old_hold_next  = old_hold & ~stat.old_clr;
    lights_on_next = lights_on;
    choice_next    = choice;
    phase_next     = phase;
    timer_next     = timer;
    relays_next    = relays;
    leds_next      = leds;
    sel            = '0;
    lights_clear   = 1'b0;
    loads          = '0;
    res.lights_sound = spc_pkg::LSND_NONE;
    res.acc_sound    = spc_pkg::ASND_NONE;
    res.valet_sound  = 1'b0;
    res.doors_sound  = spc_pkg::DSND_NONE;

    // lights hold event toggles the relay
    if (stat.hold[L] && !old_hold_next[L]) begin
      old_hold_next[L] = 1'b1;
      lights_clear     = 1'b1;
      loads.load[L]    = 1'b1;
      if (lights_on) begin
        res.lights_sound = spc_pkg::LSND_OFF;
        loads.value[L]   = spc_pkg::BLINK_LIGHTS_OFF;
        lights_on_next   = 1'b0;
      end else begin
        res.lights_sound = spc_pkg::LSND_ON;
        loads.value[L]   = spc_pkg::BLINK_LIGHTS_ON;
        lights_on_next   = 1'b1;
      end
    end

    // accessory press steps the choice or resets after a commit
    if (stat.hold[A] && !old_hold_next[A] && phase != PH_RESET) begin
      old_hold_next[A] = 1'b1;
      loads.load[A]    = 1'b1;
      loads.value[A]   = spc_pkg::BLINK_ACC;
      if (phase == PH_COMMITTED) begin
        leds_next        = '0;
        res.acc_sound    = spc_pkg::ASND_LOW;
        choice_next      = 2'd0;
        phase_next       = PH_RESET;
        old_hold_next[A] = 1'b0;
        relays_next      = '0;
      end else begin
        choice_next = choice + 2'd1;
        if (choice_next == 2'd0) begin
          leds_next     = '0;
          res.acc_sound = spc_pkg::ASND_LOW;
        end else begin
          leds_next     = 3'b001 << (choice_next - 2'd1);
          res.acc_sound = {1'b0, choice_next};
          timer_next    = 8'd0;
        end
      end
    end

    // pending choice commits once the timer passes the delay
    if (phase_next == PH_WAIT && choice_next != 2'd0 && timer_next > commit_delay) begin
      sel           = 3'b001 << (choice_next - 2'd1);
      phase_next    = PH_COMMITTED;
      leds_next     = leds_next | sel;
      relays_next   = relays_next | sel;
      res.acc_sound = spc_pkg::ASND_COMMIT;
    end

    // reset phase ends once the accessory switch lets go
    if (!stat.hold[A] && phase_next == PH_RESET) begin
      phase_next = PH_WAIT;
    end

    // valet hold event
    if (stat.hold[V] && !old_hold_next[V]) begin
      res.valet_sound  = 1'b1;
      loads.load[V]    = 1'b1;
      loads.value[V]   = spc_pkg::BLINK_VALET;
      old_hold_next[V] = 1'b1;
    end

    // doors press and release events
    if (stat.hold[D] && !old_hold_next[D]) begin
      res.doors_sound  = spc_pkg::DSND_PRESS;
      loads.load[D]    = 1'b1;
      loads.value[D]   = spc_pkg::BLINK_DOORS_ON;
      old_hold_next[D] = 1'b1;
    end else if (!stat.hold[D] && old_hold_next[D]) begin
      res.doors_sound  = spc_pkg::DSND_REL;
      loads.load[D]    = 1'b1;
      loads.value[D]   = spc_pkg::BLINK_DOORS_OFF;
      old_hold_next[D] = 1'b0;
    end

    // commit timer counts blink steps, saturating
    if (step && timer_next != 8'hFF) begin
      timer_next = timer_next + 8'd1;
    end

    res.lights_relay   = lights_on_next;
    res.acc_relays     = relays_next;
    res.indicator_leds = leds_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      old_hold  <= '0;
      lights_on <= 1'b0;
      choice    <= '0;
      phase     <= PH_WAIT;
      timer     <= '0;
      relays    <= '0;
      leds      <= '0;
    end else if (en) begin
      old_hold  <= old_hold_next;
      lights_on <= lights_on_next;
      choice    <= choice_next;
      phase     <= phase_next;
      timer     <= timer_next;
      relays    <= relays_next;
      leds      <= leds_next;
    end
  end

endmodule

[rtl/switch_panel_controller_unit.sv]
// switch panel controller: input register, one-tick update, result register
// throughput: one beat per cycle while results are taken; a held result stalls the input
// the update for a tick is one pass through debounce, event and blink logic
// reset (synchronous, active high) clears the valid flags and panel state and restores register defaults
module switch_panel_controller_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [11:0] cfg_data,
  spc_in_if.sink     sw_in,
  spc_out_if.source  res_out
);

  logic [7:0]  hold_count;
  logic [7:0]  release_level;
  logic [11:0] blink_pace;
  logic [7:0]  commit_delay;

  logic       s1_valid;
  logic [3:0] s1_pressed;
  logic       advance;

  logic                 out_valid;
  spc_pkg::ctrl_res_t   out_res;
  logic [3:0]           out_lamps;

  spc_pkg::deb_stat_t   stat;
  spc_pkg::blink_load_t loads;
  spc_pkg::ctrl_res_t   res;
  logic                 lights_clear;
  logic                 step;
  logic [3:0]           lamps_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count    <= spc_pkg::HOLD_COUNT_RST;
      release_level <= spc_pkg::RELEASE_LEVEL_RST;
      blink_pace    <= spc_pkg::BLINK_PACE_RST;
      commit_delay  <= spc_pkg::COMMIT_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spc_pkg::CFG_HOLD_COUNT:    hold_count    <= cfg_data[7:0];
        spc_pkg::CFG_RELEASE_LEVEL: release_level <= cfg_data[7:0];
        spc_pkg::CFG_BLINK_PACE:    blink_pace    <= cfg_data;
        spc_pkg::CFG_COMMIT_DELAY:  commit_delay  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // tick moves on when the result register is free or draining
  assign advance     = s1_valid && (!out_valid || res_out.ready);
  assign sw_in.ready = !s1_valid || advance;

  // input register, pressed levels in switch slot order
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sw_in.ready) begin
      s1_valid <= sw_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sw_in.ready && sw_in.valid) begin
      s1_pressed <= {sw_in.acc_switch, sw_in.doors_switch,
                     ~sw_in.valet_switch, sw_in.lights_switch};
    end
  end

  spc_debounce u_debounce (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .pressed       (s1_pressed),
    .lights_clear  (lights_clear),
    .hold_count    (hold_count),
    .release_level (release_level),
    .stat          (stat)
  );

  spc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .en           (advance),
    .stat         (stat),
    .step         (step),
    .commit_delay (commit_delay),
    .lights_clear (lights_clear),
    .loads        (loads),
    .res          (res)
  );

  spc_blink u_blink (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .blink_pace (blink_pace),
    .loads      (loads),
    .step       (step),
    .lamps_next (lamps_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res   <= res;
      out_lamps <= lamps_next;
    end
  end

  assign res_out.valid          = out_valid;
  assign res_out.lights_relay   = out_res.lights_relay;
  assign res_out.acc_relays     = out_res.acc_relays;
  assign res_out.indicator_leds = out_res.indicator_leds;
  assign res_out.switch_lamps   = out_lamps;
  assign res_out.lights_sound   = out_res.lights_sound;
  assign res_out.acc_sound      = out_res.acc_sound;
  assign res_out.valet_sound    = out_res.valet_sound;
  assign res_out.doors_sound    = out_res.doors_sound;

endmodule

[verif/switch_panel_controller_unit_tb.sv]
// testbench for the switch panel controller: predicts every tick and checks each result beat
module switch_panel_controller_unit_tb;
  import spc_pkg::*;

  typedef enum logic [1:0] {ACC_WAITING, ACC_COMMITTED, ACC_RESET, ACC_SPARE} acc_phase_t;

  typedef struct packed {
    logic       lights_relay;
    logic [2:0] acc_relays;
    logic [2:0] indicator_leds;
    logic [3:0] switch_lamps;
    logic [1:0] lights_sound;
    logic [2:0] acc_sound;
    logic       valet_sound;
    logic [1:0] doors_sound;
  } panel_result_t;

  typedef struct {
    logic [3:0] levels;  // raw switch levels, bit order lights, valet, doors, acc
    int         gap;     // idle cycles before the beat is offered
    bit         drain;   // hold the beat until every predicted result has come
  } tick_item_t;

  localparam logic [3:0] VALET_LOW    = 4'(1 << SW_VALET);
  localparam logic [3:0] PRESS_LIGHTS = 4'(1 << SW_LIGHTS);
  localparam logic [3:0] PRESS_VALET  = 4'(1 << SW_VALET);
  localparam logic [3:0] PRESS_DOORS  = 4'(1 << SW_DOORS);
  localparam logic [3:0] PRESS_ACC    = 4'(1 << SW_ACC);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  spc_in_if  sw_in ();
  spc_out_if res_out ();

  switch_panel_controller_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sw_in     (sw_in),
    .res_out   (res_out)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted panel state and register settings
  logic [7:0]  set_hold, set_release, set_commit;
  logic [11:0] set_pace;
  logic [7:0]  deb_cnt [NUM_SW];
  logic [7:0]  blink_cnt [NUM_SW];
  logic [3:0]  hold_f, old_f;
  logic        lights_on;
  logic [1:0]  acc_choice;
  acc_phase_t  acc_phase;
  logic [7:0]  commit_timer;
  logic        blink_parity;
  logic [11:0] pace_cnt;
  logic        relay_q;
  logic [2:0]  acc_rel_q, leds_q;
  logic [3:0]  lamps_q;

  panel_result_t outputs_due [$];
  tick_item_t    tick_q [$];
  tick_item_t    staged;
  bit            have_staged = 1'b0;
  int unsigned   beats_sent = 0, beats_taken = 0;
  int unsigned   results_taken = 0, results_drawn = 0;
  int            tx_quiet = 0, rx_quiet = 0, rx_stall = 0;
  int            items_made = 0, mismatches = 0, settings_used = 1;
  int            lights_toggles = 0, commits = 0, acc_resets = 0;

  // one tick of the panel: debounce, switch events, commit, blink pacing
  task automatic step_panel(input logic [3:0] levels, output panel_result_t r);
    logic [3:0]  pressed;
    logic [12:0] pace;
    logic [7:0]  c;
    logic [2:0]  sel;
    int          i;
    r = '0;
    pressed = levels ^ VALET_LOW;

    // integrating debounce of each switch
    for (i = 0; i < NUM_SW; i++) begin
      if (pressed[i]) begin
        if (deb_cnt[i] < set_hold) deb_cnt[i] = deb_cnt[i] + 8'd1;
        else hold_f[i] = 1'b1;
      end else if (deb_cnt[i] != 8'd0) begin
        if (deb_cnt[i] < set_release) begin
          hold_f[i] = 1'b0;
          if (i != SW_DOORS) old_f[i] = 1'b0;
        end
        deb_cnt[i] = deb_cnt[i] - 8'd1;
      end
    end

    // lights hold event toggles the relay
    if (hold_f[SW_LIGHTS] && !old_f[SW_LIGHTS]) begin
      old_f[SW_LIGHTS] = 1'b1;
      deb_cnt[SW_LIGHTS] = 8'd0;
      lights_toggles++;
      if (lights_on) begin
        r.lights_sound = LSND_OFF;
        blink_cnt[SW_LIGHTS] = BLINK_LIGHTS_OFF;
        lights_on = 1'b0;
        relay_q = 1'b0;
      end else begin
        r.lights_sound = LSND_ON;
        blink_cnt[SW_LIGHTS] = BLINK_LIGHTS_ON;
        lights_on = 1'b1;
        relay_q = 1'b1;
      end
    end

    // accessory press steps the choice, or clears everything after a commit
    if (hold_f[SW_ACC] && !old_f[SW_ACC] && acc_phase != ACC_RESET) begin
      old_f[SW_ACC] = 1'b1;
      blink_cnt[SW_ACC] = BLINK_ACC;
      if (acc_phase == ACC_COMMITTED) begin
        leds_q = 3'd0;
        r.acc_sound = ASND_LOW;
        acc_choice = 2'd0;
        acc_phase = ACC_RESET;
        old_f[SW_ACC] = 1'b0;
        acc_rel_q = 3'd0;
        acc_resets++;
      end else begin
        acc_choice = acc_choice + 2'd1;
        if (acc_choice == 2'd0) begin
          leds_q = 3'd0;
          r.acc_sound = ASND_LOW;
        end else begin
          leds_q = 3'b001 << (acc_choice - 2'd1);
          r.acc_sound = {1'b0, acc_choice};
          commit_timer = 8'd0;
          if (acc_choice == 2'd2) acc_phase = ACC_WAITING;
        end
      end
    end

    // pending choice commits once the timer passes the delay
    if (acc_phase == ACC_WAITING && acc_choice != 2'd0 && commit_timer > set_commit) begin
      sel = 3'b001 << (acc_choice - 2'd1);
      acc_phase = ACC_COMMITTED;
      leds_q = leds_q | sel;
      acc_rel_q = acc_rel_q | sel;
      r.acc_sound = ASND_COMMIT;
      commits++;
    end
    if (!hold_f[SW_ACC] && acc_phase == ACC_RESET) acc_phase = ACC_WAITING;

    // valet only signals
    if (hold_f[SW_VALET] && !old_f[SW_VALET]) begin
      r.valet_sound = 1'b1;
      blink_cnt[SW_VALET] = BLINK_VALET;
      old_f[SW_VALET] = 1'b1;
    end

    // doors press and release
    if (hold_f[SW_DOORS] && !old_f[SW_DOORS]) begin
      r.doors_sound = DSND_PRESS;
      blink_cnt[SW_DOORS] = BLINK_DOORS_ON;
      old_f[SW_DOORS] = 1'b1;
    end else if (!hold_f[SW_DOORS] && old_f[SW_DOORS]) begin
      r.doors_sound = DSND_REL;
      blink_cnt[SW_DOORS] = BLINK_DOORS_OFF;
      old_f[SW_DOORS] = 1'b0;
    end

    // tick divider and lamp blinking
    pace = {1'b0, pace_cnt} + 13'd1;
    if (pace > {1'b0, set_pace}) begin
      pace_cnt = 12'd0;
      if (commit_timer != 8'hFF) commit_timer = commit_timer + 8'd1;
      blink_parity = ~blink_parity;
      for (i = 0; i < NUM_SW; i++) begin
        c = blink_cnt[i];
        if ((c[6:0] & STEP_MASK) != 7'd0 && !((c & SLOW_BIT) != 8'd0 && blink_parity)) begin
          lamps_q[LAMP_POS[i]] = ~c[0];
          blink_cnt[i] = c - 8'd1;
        end
      end
    end else begin
      pace_cnt = pace[11:0];
    end

    r.lights_relay   = relay_q;
    r.acc_relays     = acc_rel_q;
    r.indicator_leds = leds_q;
    r.switch_lamps   = lamps_q;
  endtask

  // idle cycles for one beat, with stretches of none
  task automatic draw_idle(inout int quiet, output int n);
    if (quiet > 0) begin
      quiet--;
      n = 0;
    end else begin
      n = $urandom_range(0, 5);
      if ($urandom_range(0, 59) == 0) quiet = $urandom_range(20, 60);
    end
  endtask

  task automatic compare_field(input string name, input logic [3:0] want_v,
                               input logic [3:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result beat %0d, %s: expected %0h, got %0h",
                 results_taken, name, want_v, got_v);
    end
  endtask

  // accepted beats: check results, predict from switch beats
  always @(posedge clk) begin
    panel_result_t got;
    panel_result_t want;
    if (!rst) begin
      if (res_out.valid && res_out.ready) begin
        results_taken++;
        got = {res_out.lights_relay, res_out.acc_relays, res_out.indicator_leds,
               res_out.switch_lamps, res_out.lights_sound, res_out.acc_sound,
               res_out.valet_sound, res_out.doors_sound};
        if (outputs_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result beat %0d arrived with no prediction waiting", results_taken);
        end else begin
          want = outputs_due.pop_front();
          compare_field("lights_relay", want.lights_relay, got.lights_relay);
          compare_field("acc_relays", want.acc_relays, got.acc_relays);
          compare_field("indicator_leds", want.indicator_leds, got.indicator_leds);
          compare_field("switch_lamps", want.switch_lamps, got.switch_lamps);
          compare_field("lights_sound", want.lights_sound, got.lights_sound);
          compare_field("acc_sound", want.acc_sound, got.acc_sound);
          compare_field("valet_sound", want.valet_sound, got.valet_sound);
          compare_field("doors_sound", want.doors_sound, got.doors_sound);
        end
      end
      if (sw_in.valid && sw_in.ready) begin
        beats_taken++;
        step_panel({sw_in.acc_switch, sw_in.doors_switch, sw_in.valet_switch,
                    sw_in.lights_switch}, want);
        outputs_due.push_back(want);
      end
    end
  end

  // switch beat driver
  always @(negedge clk) begin
    if (rst) begin
      sw_in.valid <= 1'b0;
    end else if (beats_sent == beats_taken) begin
      if (!have_staged && tick_q.size() != 0) begin
        staged = tick_q.pop_front();
        have_staged = 1'b1;
      end
      if (!have_staged) begin
        sw_in.valid <= 1'b0;
      end else if (staged.gap > 0) begin
        staged.gap--;
        sw_in.valid <= 1'b0;
      end else if (staged.drain && outputs_due.size() != 0) begin
        sw_in.valid <= 1'b0;
      end else begin
        {sw_in.acc_switch, sw_in.doors_switch, sw_in.valet_switch, sw_in.lights_switch}
          <= staged.levels;
        sw_in.valid <= 1'b1;
        beats_sent++;
        have_staged = 1'b0;
      end
    end
  end

  // result side stalls, drawn per result beat
  always @(negedge clk) begin
    if (rst) begin
      res_out.ready <= 1'b0;
    end else begin
      if (results_drawn != results_taken) begin
        results_drawn = results_taken;
        draw_idle(rx_quiet, rx_stall);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        res_out.ready <= 1'b0;
      end else begin
        res_out.ready <= 1'b1;
      end
    end
  end

  // queue n ticks at the same raw levels
  task automatic add_run(input logic [3:0] levels, input int n);
    tick_item_t t;
    repeat (n) begin
      t.levels = levels;
      draw_idle(tx_quiet, t.gap);
      t.drain = (items_made % 150 == 75) || ($urandom_range(0, 299) == 0);
      tick_q.push_back(t);
      items_made++;
    end
  endtask

  // mostly full press and release sequences, some idle stretches and noise
  task automatic add_random_ticks(input int n);
    int         added;
    int         len;
    int         kind;
    int         h;
    logic [3:0] press;
    added = 0;
    h = set_hold;
    while (added < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        press = 4'(1 << $urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) press = 4'($urandom_range(1, 15));
        len = h + 1 + $urandom_range(0, h + 2);
        add_run(press ^ VALET_LOW, len);
        added += len;
        len = $urandom_range(1, h + 3);
        add_run(VALET_LOW, len);
        added += len;
      end else if (kind < 8) begin
        len = $urandom_range(5, 40);
        add_run(VALET_LOW, len);
        added += len;
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) add_run(4'($urandom), 1);
        added += len;
      end
    end
  endtask

  // wait until every queued beat is accepted and every result has come
  task automatic settle();
    while (tick_q.size() != 0 || have_staged || beats_sent != beats_taken ||
           outputs_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HOLD_COUNT:    set_hold = val[7:0];
      CFG_RELEASE_LEVEL: set_release = val[7:0];
      CFG_BLINK_PACE:    set_pace = val;
      CFG_COMMIT_DELAY:  set_commit = val[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] h, input logic [7:0] rl,
                           input logic [11:0] p, input logic [7:0] cd);
    settle();
    write_reg(CFG_HOLD_COUNT, {4'd0, h});
    write_reg(CFG_RELEASE_LEVEL, {4'd0, rl});
    write_reg(CFG_BLINK_PACE, p);
    write_reg(CFG_COMMIT_DELAY, {4'd0, cd});
    settings_used++;
  endtask

  // stimulus sequence
  initial begin
    int i;
    set_hold = HOLD_COUNT_RST;
    set_release = RELEASE_LEVEL_RST;
    set_pace = BLINK_PACE_RST;
    set_commit = COMMIT_DELAY_RST;
    for (i = 0; i < NUM_SW; i++) begin
      deb_cnt[i] = 8'd0;
      blink_cnt[i] = 8'd0;
    end
    hold_f = '0;
    old_f = '0;
    lights_on = 1'b0;
    acc_choice = 2'd0;
    acc_phase = ACC_WAITING;
    commit_timer = 8'd0;
    blink_parity = 1'b0;
    pace_cnt = 12'd0;
    relay_q = 1'b0;
    acc_rel_q = 3'd0;
    leds_q = 3'd0;
    lamps_q = 4'd0;

    sw_in.valid = 1'b0;
    sw_in.lights_switch = 1'b0;
    sw_in.valet_switch = 1'b1;
    sw_in.doors_switch = 1'b0;
    sw_in.acc_switch = 1'b0;
    res_out.ready = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: every switch at both levels
    add_run(4'hF ^ VALET_LOW, 1);
    add_run(VALET_LOW, 1);

    // one-tick hold, wide release, blink step every tick
    configure(8'd1, 8'd255, 12'd0, 8'd3);
    add_run((PRESS_LIGHTS | PRESS_VALET | PRESS_DOORS) ^ VALET_LOW, 2);
    add_run(VALET_LOW, 1);
    // four presses walk the choice round to zero with the low tone
    repeat (4) begin
      add_run(PRESS_ACC ^ VALET_LOW, 2);
      add_run(VALET_LOW, 1);
    end
    // choice one left alone until it commits
    add_run(PRESS_ACC ^ VALET_LOW, 2);
    add_run(VALET_LOW, 4);
    // a press after the commit resets and waits for release
    add_run(PRESS_ACC ^ VALET_LOW, 2);
    add_run(VALET_LOW, 1);

    // zero hold count sets hold on the first pressed tick
    configure(8'd0, 8'd1, 12'd0, 8'd0);
    add_run((PRESS_LIGHTS | PRESS_ACC) ^ VALET_LOW, 1);
    add_run(VALET_LOW, 2);

    // random sequences under several settings
    configure(8'd3, 8'd2, 12'd1, 8'd3);
    add_random_ticks(110);

    configure(8'd6, 8'd6, 12'd0, 8'd0);
    add_random_ticks(70);

    // commit delay of 254, timer runs into saturation
    configure(8'd2, 8'd255, 12'd0, 8'd254);
    add_run(PRESS_ACC ^ VALET_LOW, 3);
    add_run(VALET_LOW, 262);

    // largest hold count and slowest pacer
    configure(8'd255, 8'd2, 12'd4095, 8'd10);
    add_run(PRESS_LIGHTS ^ VALET_LOW, 257);
    add_run(VALET_LOW, 20);

    settle();
    repeat (10) @(posedge clk);
    $display("run covered %0d switch beats under %0d register settings",
             beats_taken, settings_used);
    $display("predicted %0d lights toggles, %0d accessory commits, %0d accessory resets",
             lights_toggles, commits, acc_resets);
    if (mismatches == 0 && outputs_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[switch_panel_controller_unit.f]
rtl/spc_pkg.sv
rtl/spc_if.sv
rtl/spc_debounce.sv
rtl/spc_blink.sv
rtl/spc_ctrl.sv
rtl/switch_panel_controller_unit.sv
verif/switch_panel_controller_unit_tb.sv
